// ----- hw/rtl/scck_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the strongly connected component counter.
// No dependencies.
package scck_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    localparam int VERTEX_W = 10;
    localparam int VCOUNT_W = 11;
    localparam int COUNT_W  = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROOT   = 1'b1;

    typedef struct packed {
        logic [VCOUNT_W-1:0] vertex_count;
        logic [VERTEX_W-1:0] first_root;
    } cfg_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] edge_src;
        logic [VERTEX_W-1:0] edge_dst;
        logic                edge_valid;
        logic                last_edge;
    } edge_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] scc_count;
        logic               load_error;
    } result_t;

endpackage

// ----- hw/rtl/scck_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for edge requests and results.
// Depends on scck_pkg.
interface scck_edge_if;
    logic                          valid;
    logic                          ready;
    logic [scck_pkg::VERTEX_W-1:0] edge_src;
    logic [scck_pkg::VERTEX_W-1:0] edge_dst;
    logic                          edge_valid;
    logic                          last_edge;

    modport source (output valid, edge_src, edge_dst, edge_valid, last_edge, input ready);
    modport sink (input valid, edge_src, edge_dst, edge_valid, last_edge, output ready);
endinterface

interface scck_result_if;
    logic                         valid;
    logic                         ready;
    logic [scck_pkg::COUNT_W-1:0] scc_count;
    logic                         load_error;

    modport source (output valid, scc_count, load_error, input ready);
    modport sink (input valid, scc_count, load_error, output ready);
endinterface

// ----- hw/rtl/scck_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module scck_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/scck_engine.sv -----
`timescale 1ns / 1ps
// Edge loader, two-pass depth-first traversal and clearing sequencer.
// Depends on scck_pkg and scck_ram.
module scck_engine #(
    parameter int MAX_VERTICES = scck_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = scck_pkg::DEF_MAX_EDGES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scck_pkg::cfg_t      cfg,
    input  logic                req_valid,
    output logic                req_ready,
    input  scck_pkg::edge_req_t req,
    output logic                res_valid,
    input  logic                res_ready,
    output scck_pkg::result_t   res
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES);
    localparam int LW  = EW + 1;
    localparam int NW  = (VW + 1 > scck_pkg::VCOUNT_W) ? VW + 1 : scck_pkg::VCOUNT_W;
    localparam int SW  = VW + LW;
    localparam int EDW = 2 * (LW + VW);

    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);
    localparam logic [NW-1:0] N_MAX     = NW'(MAX_VERTICES);
    localparam logic [VW:0]   V_MAX     = (VW + 1)'(MAX_VERTICES);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_P1_ROOT, S_P1_SCAN, S_P1_CHK,
        S_P2_SCAN, S_P2_V, S_P2_CHK, S_W_START, S_W_HEAD, S_W_STEP,
        S_W_POP, S_W_EDGE, S_W_SEEN, S_W_PUSH, S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    scck_pkg::edge_req_t ld_reg, ld_next;
    logic                store_reg, store_next;
    logic [NW-1:0]       scan_reg, scan_next;
    logic [VW:0]         fill_reg, fill_next;
    logic [LW-1:0]       edges_reg, edges_next;
    logic                err_reg, err_next;
    logic [VW:0]         count_reg, count_next;
    logic                pass2_reg, pass2_next;
    logic [VW:0]         sp_reg, sp_next;
    logic [VW-1:0]       top_v_reg, top_v_next;
    logic [LW-1:0]       top_link_reg, top_link_next;
    logic [VW-1:0]       w_reg, w_next;

    logic          hf_we, hr_we, ed_we, sn_we, fo_we, st_we;
    logic [VW-1:0] hf_waddr, hr_waddr, hf_raddr, hr_raddr;
    logic [LW-1:0] hf_wdata, hr_wdata, hf_rdata, hr_rdata;
    logic [EW-1:0] ed_waddr, ed_raddr;
    logic [EDW-1:0] ed_wdata, ed_rdata;
    logic [VW-1:0] sn_waddr, sn_raddr;
    logic [1:0]    sn_wdata, sn_rdata;
    logic [VW-1:0] fo_waddr, fo_raddr, fo_wdata, fo_rdata;
    logic [VW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rdata;

    logic [NW-1:0] vc_n, n_act, src_n, dst_n, root_n, tgt_n, fo_n;
    logic [LW-1:0] e_next_link;
    logic [VW-1:0] e_target;
    logic          seen_bit;
    logic [LW-1:0] head_sel;
    logic [1:0]    seen_mark;
    logic [NW-1:0] scan_dec;

    assign vc_n   = NW'(cfg.vertex_count);
    assign n_act  = (vc_n > N_MAX) ? N_MAX : vc_n;
    assign src_n  = NW'(req.edge_src);
    assign dst_n  = NW'(req.edge_dst);
    assign root_n = NW'(cfg.first_root);
    assign e_next_link = pass2_reg ? ed_rdata[LW+VW-1 -: LW] : ed_rdata[EDW-1 -: LW];
    assign e_target    = pass2_reg ? ed_rdata[VW-1:0] : ed_rdata[EDW-LW-1 -: VW];
    assign tgt_n       = NW'(e_target);
    assign fo_n        = NW'(fo_rdata);
    assign seen_bit    = pass2_reg ? sn_rdata[1] : sn_rdata[0];
    assign head_sel    = pass2_reg ? hr_rdata : hf_rdata;
    assign seen_mark   = pass2_reg ? 2'b11 : 2'b01;
    assign scan_dec    = scan_reg - NW'(1);

    always_comb
    begin
        state_next    = state_reg;
        ld_next       = ld_reg;
        store_next    = store_reg;
        scan_next     = scan_reg;
        fill_next     = fill_reg;
        edges_next    = edges_reg;
        err_next      = err_reg;
        count_next    = count_reg;
        pass2_next    = pass2_reg;
        sp_next       = sp_reg;
        top_v_next    = top_v_reg;
        top_link_next = top_link_reg;
        w_next        = w_reg;
        req_ready     = 1'b0;
        res_valid     = 1'b0;
        hf_we = 1'b0; hf_waddr = '0; hf_wdata = '0; hf_raddr = w_reg;
        hr_we = 1'b0; hr_waddr = '0; hr_wdata = '0; hr_raddr = w_reg;
        ed_we = 1'b0; ed_waddr = '0; ed_wdata = '0; ed_raddr = top_link_reg[EW-1:0];
        sn_we = 1'b0; sn_waddr = w_reg; sn_wdata = seen_mark; sn_raddr = w_reg;
        fo_we = 1'b0; fo_waddr = fill_reg[VW-1:0]; fo_wdata = top_v_reg;
        fo_raddr = scan_dec[VW-1:0];
        st_we = 1'b0; st_waddr = '0; st_wdata = {top_v_reg, top_link_reg};
        st_raddr = '0;

        case (state_reg)
            S_CLEAR:
            begin
                hf_we = 1'b1; hf_waddr = scan_reg[VW-1:0]; hf_wdata = NULL_LINK;
                hr_we = 1'b1; hr_waddr = scan_reg[VW-1:0]; hr_wdata = NULL_LINK;
                sn_we = 1'b1; sn_waddr = scan_reg[VW-1:0]; sn_wdata = 2'b00;
                edges_next = '0;
                fill_next  = '0;
                err_next   = 1'b0;
                count_next = '0;
                if (scan_reg == N_MAX - NW'(1))
                begin
                    scan_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + NW'(1);
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                hf_raddr  = src_n[VW-1:0];
                hr_raddr  = dst_n[VW-1:0];
                if (req_valid)
                begin
                    ld_next    = req;
                    store_next = req.edge_valid && (src_n < n_act) && (dst_n < n_act)
                                 && (edges_reg < NULL_LINK);
                    if (req.edge_valid && !((src_n < n_act) && (dst_n < n_act)
                                            && (edges_reg < NULL_LINK)))
                    begin
                        err_next = 1'b1;
                    end
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (store_reg)
                begin
                    hf_we = 1'b1; hf_waddr = VW'(ld_reg.edge_src); hf_wdata = edges_reg;
                    hr_we = 1'b1; hr_waddr = VW'(ld_reg.edge_dst); hr_wdata = edges_reg;
                    ed_we    = 1'b1;
                    ed_waddr = edges_reg[EW-1:0];
                    ed_wdata = {hf_rdata, VW'(ld_reg.edge_dst), hr_rdata, VW'(ld_reg.edge_src)};
                    edges_next = edges_reg + LW'(1);
                end
                if (ld_reg.last_edge)
                begin
                    pass2_next = 1'b0;
                    scan_next  = '0;
                    count_next = '0;
                    state_next = S_P1_ROOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_P1_ROOT:
            begin
                if (root_n < n_act)
                begin
                    w_next     = root_n[VW-1:0];
                    state_next = S_W_START;
                end
                else
                begin
                    state_next = S_P1_SCAN;
                end
            end
            S_P1_SCAN:
            begin
                sn_raddr = scan_reg[VW-1:0];
                if (scan_reg == n_act)
                begin
                    pass2_next = 1'b1;
                    scan_next  = NW'(fill_reg);
                    state_next = S_P2_SCAN;
                end
                else
                begin
                    state_next = S_P1_CHK;
                end
            end
            S_P1_CHK:
            begin
                if (!sn_rdata[0])
                begin
                    w_next     = scan_reg[VW-1:0];
                    state_next = S_W_START;
                end
                else
                begin
                    scan_next  = scan_reg + NW'(1);
                    state_next = S_P1_SCAN;
                end
            end
            S_P2_SCAN:
            begin
                if (scan_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_P2_V;
                end
            end
            S_P2_V:
            begin
                sn_raddr = fo_rdata;
                if (fo_n < n_act)
                begin
                    w_next     = fo_rdata;
                    state_next = S_P2_CHK;
                end
                else
                begin
                    scan_next  = scan_dec;
                    state_next = S_P2_SCAN;
                end
            end
            S_P2_CHK:
            begin
                if (!sn_rdata[1])
                begin
                    count_next = count_reg + (VW + 1)'(1);
                    state_next = S_W_START;
                end
                else
                begin
                    scan_next  = scan_dec;
                    state_next = S_P2_SCAN;
                end
            end
            S_W_START:
            begin
                sn_we      = 1'b1;
                state_next = S_W_HEAD;
            end
            S_W_HEAD:
            begin
                top_v_next    = w_reg;
                top_link_next = head_sel;
                sp_next       = (VW + 1)'(1);
                state_next    = S_W_STEP;
            end
            S_W_STEP:
            begin
                st_raddr = sp_reg[VW-1:0] - VW'(2);
                if (top_link_reg == NULL_LINK)
                begin
                    if (!pass2_reg && (fill_reg < V_MAX))
                    begin
                        fo_we     = 1'b1;
                        fill_next = fill_reg + (VW + 1)'(1);
                    end
                    if (sp_reg == (VW + 1)'(1))
                    begin
                        state_next = pass2_reg ? S_P2_SCAN : S_P1_SCAN;
                    end
                    else
                    begin
                        state_next = S_W_POP;
                    end
                end
                else
                begin
                    state_next = S_W_EDGE;
                end
            end
            S_W_POP:
            begin
                top_v_next    = st_rdata[SW-1 -: VW];
                top_link_next = st_rdata[LW-1:0];
                sp_next       = sp_reg - (VW + 1)'(1);
                state_next    = S_W_STEP;
            end
            S_W_EDGE:
            begin
                top_link_next = e_next_link;
                w_next        = e_target;
                sn_raddr      = e_target;
                state_next    = (tgt_n < n_act) ? S_W_SEEN : S_W_STEP;
            end
            S_W_SEEN:
            begin
                if (!seen_bit && (sp_reg < V_MAX))
                begin
                    sn_we    = 1'b1;
                    st_we    = 1'b1;
                    st_waddr = sp_reg[VW-1:0] - VW'(1);
                    state_next = S_W_PUSH;
                end
                else
                begin
                    state_next = S_W_STEP;
                end
            end
            S_W_PUSH:
            begin
                top_v_next    = w_reg;
                top_link_next = head_sel;
                sp_next       = sp_reg + (VW + 1)'(1);
                state_next    = S_W_STEP;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    scan_next  = '0;
                    state_next = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ld_reg       <= '0;
            store_reg    <= 1'b0;
            scan_reg     <= '0;
            fill_reg     <= '0;
            edges_reg    <= '0;
            err_reg      <= 1'b0;
            count_reg    <= '0;
            pass2_reg    <= 1'b0;
            sp_reg       <= '0;
            top_v_reg    <= '0;
            top_link_reg <= '0;
            w_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ld_reg       <= ld_next;
            store_reg    <= store_next;
            scan_reg     <= scan_next;
            fill_reg     <= fill_next;
            edges_reg    <= edges_next;
            err_reg      <= err_next;
            count_reg    <= count_next;
            pass2_reg    <= pass2_next;
            sp_reg       <= sp_next;
            top_v_reg    <= top_v_next;
            top_link_reg <= top_link_next;
            w_reg        <= w_next;
        end
    end

    assign res.scc_count  = scck_pkg::COUNT_W'(count_reg);
    assign res.load_error = err_reg;

    scck_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_fwd_head (
        .clk(clk), .we(hf_we), .waddr(hf_waddr), .wdata(hf_wdata),
        .raddr(hf_raddr), .rdata(hf_rdata)
    );

    scck_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_rev_head (
        .clk(clk), .we(hr_we), .waddr(hr_waddr), .wdata(hr_wdata),
        .raddr(hr_raddr), .rdata(hr_rdata)
    );

    scck_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
        .clk(clk), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
        .raddr(ed_raddr), .rdata(ed_rdata)
    );

    scck_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_seen (
        .clk(clk), .we(sn_we), .waddr(sn_waddr), .wdata(sn_wdata),
        .raddr(sn_raddr), .rdata(sn_rdata)
    );

    scck_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_finish (
        .clk(clk), .we(fo_we), .waddr(fo_waddr), .wdata(fo_wdata),
        .raddr(fo_raddr), .rdata(fo_rdata)
    );

    scck_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= V_MAX) else $error("walk stack overflow");
    a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edges_reg <= NULL_LINK) else $error("edge count overflow");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= V_MAX) else $error("finish order overflow");
    a_count_fill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fill_reg) else $error("more components than finished vertices");
    a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> state_reg == S_CLEAR && scan_reg == '0)
        else $error("result not followed by clearing pass");
`endif

endmodule

// ----- hw/rtl/scc_count_kosaraju.sv -----
`timescale 1ns / 1ps
// Top level of the strongly connected component counter: config registers,
// result register and traversal engine. Depends on scck_pkg, scck_if, scck_engine.
//
//   channel  | dir | payload                                  | handshake
//   edges    | in  | edge_src, edge_dst, edge_valid, last_edge| valid/ready
//   result   | out | scc_count, load_error                    | valid/ready
//   cfg      | in  | cfg_index, cfg_data                      | cfg_we
//
// Each edge request passes through a head read, then a list write.
// A request marked last runs both traversals: a first sweep over the vertices, a second
// over the finish entries, and walks that step edge by edge with pushes and pops,
// all paced by the registered RAM reads.
// After reset and after each result a clearing pass over all MAX_VERTICES entries
// runs with edges.ready low; config writes are still taken.
// The result waits in its register while the clearing pass proceeds.
module scc_count_kosaraju #(
    parameter int MAX_VERTICES = scck_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = scck_pkg::DEF_MAX_EDGES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    scck_edge_if.sink                        edges,
    scck_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [scck_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scck_pkg::CFG_DATA_W-1:0]  cfg_data
);

    scck_pkg::cfg_t      cfg_reg, cfg_next;
    scck_pkg::result_t   res_reg, res_next, eng_res;
    logic                res_valid_reg, res_valid_next;
    logic                eng_valid, eng_ready;
    scck_pkg::edge_req_t req;

    assign req.edge_src   = edges.edge_src;
    assign req.edge_dst   = edges.edge_dst;
    assign req.edge_valid = edges.edge_valid;
    assign req.last_edge  = edges.last_edge;

    assign eng_ready = !res_valid_reg || result.ready;

    always_comb
    begin
        cfg_next       = cfg_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scck_pkg::REG_VERTEX_COUNT: cfg_next.vertex_count = cfg_data;
                scck_pkg::REG_FIRST_ROOT:
                    cfg_next.first_root = cfg_data[scck_pkg::VERTEX_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (eng_valid && eng_ready)
        begin
            res_next       = eng_res;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.scc_count  = res_reg.scc_count;
    assign result.load_error = res_reg.load_error;

    scck_engine #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES)
    ) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .req_valid(edges.valid),
        .req_ready(edges.ready),
        .req(req),
        .res_valid(eng_valid),
        .res_ready(eng_ready),
        .res(eng_res)
    );

endmodule
